>>> src/kdhd_pkg.sv
package kdhd_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_ENABLE  = 2'd3;

    localparam int CFG_DATA_W = 16;
    localparam int TIME_W     = 16;

    localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 16'd25;

    // poll commands
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // event enable bits
    localparam int EN_DOWN    = 0;
    localparam int EN_UP      = 1;
    localparam int EN_PRESSED = 2;
    localparam int EN_HELD    = 3;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    typedef struct packed {
        logic              invert;
        logic [TIME_W-1:0] hold_ms;
        logic [TIME_W-1:0] debounce_time;
        logic [3:0]        event_enable;
    } cfg_t;

    // declared msb first so key_is_down lands in bit 0
    typedef struct packed {
        logic held_event;
        logic pressed_event;
        logic up_event;
        logic down_event;
        logic key_is_held;
        logic key_is_down;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

>>> src/kdhd_core.sv
module kdhd_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic                          cmd,
    input  logic                          raw_level,
    input  logic [kdhd_pkg::TIME_W-1:0]   now_ms,
    input  kdhd_pkg::cfg_t                cfg,
    output kdhd_pkg::result_t             result
);
    import kdhd_pkg::*;

    logic              enabled_reg, enabled_next;
    logic              prev_level_reg, prev_level_next;
    logic              stable_reg, stable_next;
    logic              held_reg, held_next;
    logic [TIME_W-1:0] change_time_reg, change_time_next;

    logic              level;
    logic [TIME_W-1:0] elapsed;
    logic              held_mid;

    always_comb begin
        level            = raw_level ^ cfg.invert;
        enabled_next     = enabled_reg;
        prev_level_next  = prev_level_reg;
        stable_next      = stable_reg;
        held_next        = held_reg;
        change_time_next = change_time_reg;
        held_mid         = held_reg;
        result           = '0;

        if (level != prev_level_reg) begin
            change_time_next = now_ms;
        end
        elapsed = now_ms - change_time_next;

        if (cmd == CMD_START) begin
            stable_next      = level;
            prev_level_next  = level;
            enabled_next     = 1'b1;
            change_time_next = change_time_reg;
        end else if (enabled_reg) begin
            if (elapsed >= cfg.debounce_time) begin
                if (level != stable_reg) begin
                    stable_next = level;
                    result.down_event = level & cfg.event_enable[EN_DOWN];
                    // key up clears held only when its event is enabled
                    if (!level && cfg.event_enable[EN_UP]) begin
                        held_mid        = 1'b0;
                        result.up_event = 1'b1;
                    end
                end
                result.pressed_event = stable_next & cfg.event_enable[EN_PRESSED];
                held_next = held_mid;
                if (elapsed >= cfg.hold_ms && level != held_mid) begin
                    held_next         = level;
                    result.held_event = level & cfg.event_enable[EN_HELD];
                end
            end
            prev_level_next = level;
        end else begin
            change_time_next = change_time_reg;
        end

        result.key_is_down = stable_next;
        result.key_is_held = held_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg     <= 1'b0;
            prev_level_reg  <= 1'b0;
            stable_reg      <= 1'b0;
            held_reg        <= 1'b0;
            change_time_reg <= '0;
        end else if (step) begin
            enabled_reg     <= enabled_next;
            prev_level_reg  <= prev_level_next;
            stable_reg      <= stable_next;
            held_reg        <= held_next;
            change_time_reg <= change_time_next;
        end
    end

endmodule

>>> src/key_debounce_hold_detector.sv
// channel | dir | handshake             | payload
// s_      | in  | s_tvalid / s_tready   | s_tuser cmd, s_tdata raw_level, now_ms
// m_      | out | m_tvalid / m_tready   | m_tdata key state and events
// cfg_    | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one poll per cycle sustained while m_tready is high; a poll is held in the input register,
// is evaluated against the key state there and is registered into m_tdata when it advances.
// aresetn is synchronous, active low; it clears key state, valid flags and
// loads the register defaults (debounce 25 ms, everything else 0).
// m_tready low while a result is held stalls both stages; s_tready stays high while a slot is free.
// cfg_ready is always high.
module key_debounce_hold_detector (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [kdhd_pkg::S_TDATA_W-1:0]    s_tdata,   // raw_level, now_ms[15:0], pad
    input  logic                              s_tuser,   // cmd
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [kdhd_pkg::M_TDATA_W-1:0]    m_tdata,   // key_is_down, key_is_held,
                                                         // down_event, up_event,
                                                         // pressed_event, held_event, pad
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kdhd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kdhd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import kdhd_pkg::*;

    cfg_t              cfg_reg;
    logic              in_vld_reg;
    logic              in_cmd_reg;
    logic              in_level_reg;
    logic [TIME_W-1:0] in_now_reg;
    logic              out_vld_reg;
    result_t           out_reg;
    result_t           result;
    logic              advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready  = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.invert        <= 1'b0;
            cfg_reg.hold_ms       <= '0;
            cfg_reg.debounce_time <= DEBOUNCE_RESET;
            cfg_reg.event_enable  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_INVERT:        cfg_reg.invert        <= cfg_data[0];
                CFG_HOLD_MS:       cfg_reg.hold_ms       <= cfg_data[TIME_W-1:0];
                CFG_DEBOUNCE_TIME: cfg_reg.debounce_time <= cfg_data[TIME_W-1:0];
                CFG_EVENT_ENABLE:  cfg_reg.event_enable  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg   <= s_tuser;
            in_level_reg <= s_tdata[0];
            in_now_reg   <= s_tdata[TIME_W:1];
        end
    end

    kdhd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .cmd       (in_cmd_reg),
        .raw_level (in_level_reg),
        .now_ms    (in_now_reg),
        .cfg       (cfg_reg),
        .result    (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(M_TDATA_W-RESULT_W){1'b0}}, out_reg};

endmodule
